@@ src/msr_pkg.sv @@
// Shared types for the modular square root block.
package msr_pkg;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NOROOT = 2'd1,
    ST_UNSUP  = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // Stand-ins for the small constant multipliers used to build 2g and 4g.
  localparam int unsigned TWO  = 2;
  localparam int unsigned FOUR = 4;

endpackage

@@ src/msr_mulmod.sv @@
// Bit-serial modular multiplier: shift-and-add with one modular add per cycle.
module msr_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] res
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DBL  = 3'b010,
    PH_ADD  = 3'b100
  } phase_t;

  phase_t            ph_r, ph_nxt;
  logic [WIDTH-1:0]  acc_r, acc_nxt;
  logic [WIDTH-1:0]  a_r, a_nxt;
  logic [WIDTH-1:0]  b_r, b_nxt;
  logic [WIDTH-1:0]  m_r, m_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  logic [WIDTH-1:0]  opnd;
  logic [WIDTH-1:0]  gap;
  logic [WIDTH-1:0]  sum;
  logic              advance;

  // (acc + opnd) mod m without leaving WIDTH bits
  assign opnd = (ph_r == PH_ADD) ? a_r : acc_r;
  assign gap  = m_r - opnd;
  assign sum  = (acc_r >= gap) ? (acc_r - gap) : (acc_r + opnd);

  always_comb begin
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    advance  = 1'b0;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          a_nxt   = a;
          b_nxt   = b;
          m_nxt   = m;
          acc_nxt = '0;
          cnt_nxt = CNT_W'(WIDTH);
          ph_nxt  = PH_DBL;
        end
      end
      PH_DBL: begin
        acc_nxt = sum;
        if (b_r[WIDTH-1]) begin
          ph_nxt = PH_ADD;
        end else begin
          advance = 1'b1;
        end
      end
      PH_ADD: begin
        acc_nxt = sum;
        advance = 1'b1;
      end
      default: ph_nxt = PH_IDLE;
    endcase
    if (advance) begin
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        ph_nxt   = PH_IDLE;
        done_nxt = 1'b1;
      end else begin
        ph_nxt = PH_DBL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

@@ src/modular_square_root_top.sv @@
// Modular square root for prime moduli 3 mod 4 and 5 mod 8, top level.
// One word in, one word out. Every modular product runs through a single bit-serial
// multiplier that does one modular add per cycle; an exponentiation is WIDTH squarings
// and up to WIDTH multiplies. A 3 mod 4 modulus costs one exponentiation and one check
// product; a 5 mod 8 modulus costs up to two exponentiations and three products.
// Out-of-range, zero and unsupported inputs skip the multiplier and go straight to
// the output. A new word is taken once the previous one is done, while its result
// still waits in the output register.
module modular_square_root_top import msr_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // cfg_data: modulus
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [WIDTH-1:0]                     cfg_data,
  // in_tdata: value
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]           in_tdata,
  // out_tdata: root, other_root
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((2*WIDTH+7)/8)*8-1:0]         out_tdata,
  // out_tuser: status
  output logic [1:0]                           out_tuser
);

  localparam int OUT_W = ((2*WIDTH+7)/8)*8;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_PSQ     = 15'h0002,
    S_PSQ_W   = 15'h0004,
    S_PMUL    = 15'h0008,
    S_PMUL_W  = 15'h0010,
    S_PDONE   = 15'h0020,
    S_VSQ     = 15'h0040,
    S_VSQ_W   = 15'h0080,
    S_G2      = 15'h0100,
    S_G2_W    = 15'h0200,
    S_G4      = 15'h0400,
    S_G4_W    = 15'h0800,
    S_FMUL    = 15'h1000,
    S_FMUL_W  = 15'h2000,
    S_OUT     = 15'h4000
  } state_t;

  // What the running exponentiation is for
  typedef enum logic [3:0] {
    STG_A = 4'b0001,  // 3 mod 4 candidate
    STG_Z = 4'b0010,  // 5 mod 8 test power
    STG_Y = 4'b0100,  // 5 mod 8 root when z is one
    STG_T = 4'b1000   // (4g)^u when z is minus one
  } stage_t;

  state_t            state_r, state_nxt;
  stage_t            stage_r, stage_nxt;
  status_t           stat_r, stat_nxt;
  logic [WIDTH-1:0]  modulus_r;
  logic [WIDTH-1:0]  p_r, p_nxt;
  logic [WIDTH-1:0]  g_r, g_nxt;
  logic [WIDTH-1:0]  base_r, base_nxt;
  logic [WIDTH-1:0]  x_r, x_nxt;
  logic [WIDTH-1:0]  e_r, e_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [WIDTH-1:0]  g2_r, g2_nxt;
  logic [WIDTH-1:0]  y_r, y_nxt;

  logic              out_valid_r;
  logic [WIDTH-1:0]  out_root_r;
  logic [WIDTH-1:0]  out_other_r;
  status_t           out_stat_r;
  logic              out_load;
  logic              found_nz;

  logic [WIDTH-1:0]  g_in;
  logic              in_fire;

  logic              mul_start;
  logic [WIDTH-1:0]  mul_a;
  logic [WIDTH-1:0]  mul_b;
  logic              mul_done;
  logic [WIDTH-1:0]  mul_res;

  logic              pow_go;
  logic [WIDTH-1:0]  pow_base;
  logic [WIDTH-1:0]  pow_e;
  stage_t            pow_stg;
  logic              bit_next;

  assign g_in      = in_tdata[WIDTH-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  msr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (p_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    stat_nxt  = stat_r;
    p_nxt     = p_r;
    g_nxt     = g_r;
    base_nxt  = base_r;
    x_nxt     = x_r;
    e_nxt     = e_r;
    ecnt_nxt  = ecnt_r;
    g2_nxt    = g2_r;
    y_nxt     = y_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    pow_go    = 1'b0;
    pow_base  = '0;
    pow_e     = '0;
    pow_stg   = STG_A;
    bit_next  = 1'b0;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          g_nxt = g_in;
          p_nxt = modulus_r;
          y_nxt = '0;
          if (g_in >= modulus_r) begin
            stat_nxt  = ST_RANGE;
            state_nxt = S_OUT;
          end else if (g_in == '0) begin
            stat_nxt  = ST_FOUND;
            state_nxt = S_OUT;
          end else if (modulus_r[1:0] == 2'b11) begin
            pow_go   = 1'b1;
            pow_base = g_in;
            pow_e    = (modulus_r >> 2) + WIDTH'(1);
            pow_stg  = STG_A;
          end else if (modulus_r[2:0] == 3'b101) begin
            // 2u + 1 with u = p >> 3
            pow_go   = 1'b1;
            pow_base = g_in;
            pow_e    = ((modulus_r >> 3) << 1) | WIDTH'(1);
            pow_stg  = STG_Z;
          end else begin
            stat_nxt  = ST_UNSUP;
            state_nxt = S_OUT;
          end
        end
      end
      S_PSQ: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
        state_nxt = S_PSQ_W;
      end
      S_PSQ_W: begin
        if (mul_done) begin
          x_nxt = mul_res;
          if (e_r[WIDTH-1]) begin
            state_nxt = S_PMUL;
          end else begin
            bit_next = 1'b1;
          end
        end
      end
      S_PMUL: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = base_r;
        state_nxt = S_PMUL_W;
      end
      S_PMUL_W: begin
        if (mul_done) begin
          x_nxt    = mul_res;
          bit_next = 1'b1;
        end
      end
      S_PDONE: begin
        unique case (stage_r)
          STG_A: state_nxt = S_VSQ;
          STG_Z: begin
            if (x_r == WIDTH'(1)) begin
              pow_go   = 1'b1;
              pow_base = g_r;
              pow_e    = (p_r >> 3) + WIDTH'(1);
              pow_stg  = STG_Y;
            end else if (x_r == p_r - WIDTH'(1)) begin
              state_nxt = S_G2;
            end else begin
              stat_nxt  = ST_NOROOT;
              state_nxt = S_OUT;
            end
          end
          STG_Y: begin
            y_nxt     = x_r;
            stat_nxt  = ST_FOUND;
            state_nxt = S_OUT;
          end
          STG_T: state_nxt = S_FMUL;
          default: state_nxt = S_FMUL;
        endcase
      end
      S_VSQ: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
        state_nxt = S_VSQ_W;
      end
      S_VSQ_W: begin
        if (mul_done) begin
          y_nxt     = x_r;
          stat_nxt  = (mul_res == g_r) ? ST_FOUND : ST_NOROOT;
          state_nxt = S_OUT;
        end
      end
      S_G2: begin
        mul_start = 1'b1;
        mul_a     = g_r;
        mul_b     = WIDTH'(TWO);
        state_nxt = S_G2_W;
      end
      S_G2_W: begin
        if (mul_done) begin
          g2_nxt    = mul_res;
          state_nxt = S_G4;
        end
      end
      S_G4: begin
        mul_start = 1'b1;
        mul_a     = g_r;
        mul_b     = WIDTH'(FOUR);
        state_nxt = S_G4_W;
      end
      S_G4_W: begin
        if (mul_done) begin
          pow_go   = 1'b1;
          pow_base = mul_res;
          pow_e    = p_r >> 3;
          pow_stg  = STG_T;
        end
      end
      S_FMUL: begin
        mul_start = 1'b1;
        mul_a     = g2_r;
        mul_b     = x_r;
        state_nxt = S_FMUL_W;
      end
      S_FMUL_W: begin
        if (mul_done) begin
          y_nxt     = mul_res;
          stat_nxt  = ST_FOUND;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // exponent bits go msb first, WIDTH of them
    if (bit_next) begin
      e_nxt    = e_r << 1;
      ecnt_nxt = ecnt_r - CNT_W'(1);
      state_nxt = (ecnt_r == CNT_W'(1)) ? S_PDONE : S_PSQ;
    end

    if (pow_go) begin
      base_nxt  = pow_base;
      e_nxt     = pow_e;
      x_nxt     = WIDTH'(1);
      ecnt_nxt  = CNT_W'(WIDTH);
      stage_nxt = pow_stg;
      state_nxt = S_PSQ;
    end
  end

  assign found_nz = (stat_r == ST_FOUND) && (g_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= WIDTH'(3);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    stage_r <= stage_nxt;
    stat_r  <= stat_nxt;
    p_r     <= p_nxt;
    g_r     <= g_nxt;
    base_r  <= base_nxt;
    x_r     <= x_nxt;
    e_r     <= e_nxt;
    ecnt_r  <= ecnt_nxt;
    g2_r    <= g2_nxt;
    y_r     <= y_nxt;
    if (out_load) begin
      out_root_r  <= found_nz ? y_r : '0;
      out_other_r <= found_nz ? (p_r - y_r) : '0;
      out_stat_r  <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_other_r, out_root_r});
  assign out_tuser  = out_stat_r;

endmodule

@@ src/msr_checker.sv @@
// Port-level checks for the modular square root top level, with its bind.
module msr_checker import msr_pkg::*; #(
  parameter int WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [((2*WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                   out_tuser
);

  logic [WIDTH-1:0] root;
  logic [WIDTH-1:0] other;
  logic             found;

  assign root  = out_tdata[WIDTH-1:0];
  assign other = out_tdata[2*WIDTH-1:WIDTH];
  assign found = (out_tuser == ST_FOUND);

  // only one word in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after accept");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found |-> root == '0 && other == '0)
    else $error("roots not zero on failure status");

  // a found root is zero only for a zero input, and then both are zero
  a_roots_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && found |-> (root == '0) == (other == '0))
    else $error("root and other root disagree on zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

endmodule

bind modular_square_root_top msr_checker #(.WIDTH(WIDTH)) u_msr_checker (.*);

@@ tb/modular_square_root_top_test.sv @@
// Self-checking testbench for the modular square root block: directed and random residues.
module modular_square_root_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import msr_pkg::*;

  localparam int W = 32;
  // slowest correct run: 144 words; stalls add little
  localparam int CYCLE_LIMIT = 10_000_000;

  localparam int SEND_IDLE[4]  = '{0, 60, 0, 25};
  localparam int RECV_STALL[4] = '{0, 0, 60, 25};
  localparam logic [W-1:0] RANDOM_MODULI[10] = '{
    32'd7, 32'd13, 32'd29, 32'd2147483647, 32'd4294967291,
    32'd4294967197, 32'd4294967189, 32'hFFFF_FFFF, 32'd3, 32'd5
  };

  typedef struct packed {
    logic [W-1:0] root;
    logic [W-1:0] other_root;
    status_t      status;
  } sqrt_result_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [W-1:0]   cfg_data = '0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [W-1:0]   in_tdata = '0;     // value
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [2*W-1:0] out_tdata;         // root, other_root
  logic [1:0]     out_tuser;         // status

  logic [W-1:0]   modulus_shadow = 32'd3;
  logic [W-1:0]   pending_values[$];
  sqrt_result_t   expected_roots[$];
  sqrt_result_t   want;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             values_queued = 0;
  int             results_seen = 0;
  int             error_count = 0;
  int             cycle_count = 0;

  modular_square_root_top #(.WIDTH(W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned x;
    x = 1;
    for (int i = W - 1; i >= 0; i--) begin
      x = mul_mod(x, x, m);
      if (e[i]) x = mul_mod(x, b, m);
    end
    return x;
  endfunction

  function automatic sqrt_result_t predict_root(input logic [W-1:0] value,
                                                input logic [W-1:0] modulus);
    longint unsigned g, p, y, z, u, g2, g4;
    sqrt_result_t r;
    g = 64'(value);
    p = 64'(modulus);
    y = 0;
    r = '0;
    if (g >= p) begin
      r.status = ST_RANGE;
    end else if (g == 0) begin
      r.status = ST_FOUND;
    end else if (p[1:0] == 2'b11) begin
      y = pow_mod(g, (p >> 2) + 1, p);
      if (mul_mod(y, y, p) == g) r.status = ST_FOUND;
      else r.status = ST_NOROOT;
    end else if (p[2:0] == 3'b101) begin
      u = p >> 3;
      z = pow_mod(g, 2 * u + 1, p);
      if (z == 1) begin
        y = pow_mod(g, u + 1, p);
        r.status = ST_FOUND;
      end else if (z == p - 1) begin
        g2 = (g + g) % p;
        g4 = (g2 + g2) % p;
        y = mul_mod(g2, pow_mod(g4, u, p), p);
        r.status = ST_FOUND;
      end else begin
        r.status = ST_NOROOT;
      end
    end else begin
      r.status = ST_UNSUP;
    end
    if (r.status == ST_FOUND && g != 0) begin
      r.root       = y[W-1:0];
      r.other_root = p[W-1:0] - y[W-1:0];
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic write_modulus(input logic [W-1:0] p);
    cfg_data  <= p;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_shadow = p;
  endtask

  task automatic wait_all_done();
    while (results_seen < values_queued) @(posedge clk);
  endtask

  // mostly true squares mod p, some arbitrary residues, some out of range
  task automatic queue_random_values(input int n);
    longint unsigned p, x;
    int kind;
    p = 64'(modulus_shadow);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (p < 2) begin
        pending_values.push_back($urandom);
      end else if (kind < 70) begin
        x = 64'($urandom_range(W'(p - 1)));
        pending_values.push_back(W'((x * x) % p));
      end else if (kind < 85) begin
        pending_values.push_back($urandom_range(W'(p - 1)));
      end else if (p == 32'hFFFF_FFFF) begin
        pending_values.push_back(32'hFFFF_FFFF);
      end else begin
        pending_values.push_back($urandom_range(32'hFFFF_FFFF, W'(p)));
      end
      values_queued++;
    end
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // driver: one word per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_roots.push_back(predict_root(in_tdata, modulus_shadow));
      if (!in_tvalid || in_tready) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_values.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_roots.size() == 0) begin
          flag_error($sformatf("unexpected result %h status %0d", out_tdata, out_tuser));
        end else begin
          want = expected_roots.pop_front();
          if (out_tdata[W-1:0] !== want.root)
            flag_error($sformatf("root %h, want %h", out_tdata[W-1:0], want.root));
          if (out_tdata[2*W-1:W] !== want.other_root)
            flag_error($sformatf("other_root %h, want %h", out_tdata[2*W-1:W],
                                 want.other_root));
          if (out_tuser !== want.status)
            flag_error($sformatf("status %0d, want %0d", out_tuser, want.status));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_square_root_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset modulus 3: zero, root 1, non-residue 2, range edges
    pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
    values_queued += pending_values.size();
    wait_all_done();

    // 5 mod 8: z = 1 path, z = p-1 paths, non-residue, zero, range
    write_modulus(32'd13);
    pending_values = '{32'd1, 32'd4, 32'd2, 32'd12, 32'd0, 32'd13};
    values_queued += pending_values.size();
    wait_all_done();

    write_modulus(32'd4294967291);
    pending_values = '{32'd4294967290, 32'd1, 32'h8000_0000, 32'd4294967291};
    values_queued += pending_values.size();
    wait_all_done();

    // composite 3 mod 4, all ones
    write_modulus(32'hFFFF_FFFF);
    pending_values = '{32'hFFFF_FFFE, 32'd1};
    values_queued += pending_values.size();
    wait_all_done();

    // unsupported classes: 1 mod 8, even, one; zero modulus rejects everything
    write_modulus(32'd17);
    pending_values = '{32'd5, 32'd0, 32'd17};
    values_queued += pending_values.size();
    wait_all_done();
    write_modulus(32'd10);
    pending_values = '{32'd3};
    values_queued += pending_values.size();
    wait_all_done();
    write_modulus(32'd1);
    pending_values = '{32'd0, 32'd1};
    values_queued += pending_values.size();
    wait_all_done();
    write_modulus(32'd0);
    pending_values = '{32'd0};
    values_queued += pending_values.size();
    wait_all_done();

    for (int ph = 0; ph < 10; ph++) begin
      send_idle_pct  = SEND_IDLE[ph % 4];
      recv_stall_pct = RECV_STALL[ph % 4];
      if (ph == 9) write_modulus($urandom);
      else write_modulus(RANDOM_MODULI[ph]);
      queue_random_values(6);
      // sender holds off until the block has fully drained
      if (ph % 3 == 1) wait_all_done();
      queue_random_values(6);
      wait_all_done();
    end

    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("modular_square_root_top_test OK");
    end else begin
      $display("modular_square_root_top_test NOT OK");
    end
    $finish;
  end

endmodule
